@@ rtl/core/itr_pkg.sv @@
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types, sizes and the digit glyph function for the radix digit converter.
// ----------------------------------------------------------------------------
package itr_pkg;

    // Sizes of the value and of the digit store
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);

    // Quotient bits retired by the divider per cycle
    localparam int STEP_BITS   = 4;
    localparam int DIV_STEPS   = VALUE_WIDTH / STEP_BITS;
    localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Radix register
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_EMIT
    } ctrl_state_t;

    // Clamp the register value to the supported bases
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        begin
            b = r;
            if (r < RADIX_MIN) begin
                b = RADIX_MIN;
            end else if (r > RADIX_MAX) begin
                b = RADIX_MAX;
            end
            return b;
        end
    endfunction

    // Map a digit to its ASCII glyph, upper-case letters above nine
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        begin
            if (d < DIGIT_W'(10)) begin
                c = CHAR_W'(8'h30) + CHAR_W'(d);
            end else begin
                c = CHAR_W'(8'h41) + CHAR_W'(d - DIGIT_W'(10));
            end
            return c;
        end
    endfunction

endpackage

@@ rtl/core/itr_divider.sv @@
// ----------------------------------------------------------------------------
// itr_divider
// Iterative restoring divider of the working value by a small base, a few
// quotient bits per cycle; gives quotient and remainder with a done pulse.
// ----------------------------------------------------------------------------
module itr_divider
    import itr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_W-1:0]     divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [DIGIT_W-1:0]     remainder
);

    logic                   running_reg, running_next;
    logic                   done_reg, done_next;
    logic [STEP_CNT_W-1:0]  step_reg, step_next;
    logic [VALUE_WIDTH-1:0] work_reg, work_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;

    logic [VALUE_WIDTH-1:0] step_work;
    logic [DIGIT_W-1:0]     step_rem;

    // One division step: shift in dividend bits, compare and subtract
    always_comb begin
        logic [RADIX_W-1:0]     r;
        logic [VALUE_WIDTH-1:0] w;
        r = RADIX_W'(rem_reg);
        w = work_reg;
        for (int i = 0; i < STEP_BITS; i++) begin
            r = {r[DIGIT_W-1:0], w[VALUE_WIDTH-1]};
            w = {w[VALUE_WIDTH-2:0], 1'b0};
            if (r >= divisor) begin
                r    = r - divisor;
                w[0] = 1'b1;
            end
        end
        step_work = w;
        step_rem  = r[DIGIT_W-1:0];
    end

    // Load on start, then advance one step per cycle
    always_comb begin
        running_next = running_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        if (start) begin
            running_next = 1'b1;
            step_next    = '0;
            work_next    = dividend;
            rem_next     = '0;
        end else if (running_reg) begin
            work_next = step_work;
            rem_next  = step_rem;
            step_next = step_reg + STEP_CNT_W'(1);
            if (step_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= '0;
        end else begin
            running_reg <= running_next;
            done_reg    <= done_next;
            step_reg    <= step_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/integer_to_radix_digits_unit.sv @@
// Sequence: for a value with n digits, the divider runs eight four-bit steps
// per digit plus a write-back, and then each digit is read from the store and
// emitted; n is at most 32 (base 2, full value).
// Throughput: one request at a time; s_tready is high only while idle.
// Reset: synchronous active-low aresetn returns to idle and sets radix to 16.
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts an unsigned value to ASCII digits in base 2..16, most significant
// first, with tlast on the final digit. Remainders are kept in a small store
// and read back in reverse order.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit
    import itr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [RADIX_W-1:0]     cfg_data,    // radix
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] s_tdata,     // value
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,     // digit_char [6:0], zero pad [7]
    output logic                   m_tlast      // last_digit
);

    ctrl_state_t            state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic [DIGIT_W-1:0]     digit_mem [MAX_DIGITS];

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [DIGIT_W-1:0]     div_remainder;
    logic                   mem_we;
    logic                   mem_re;

    itr_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (clamp_radix(radix_reg)),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Radix register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            radix_reg <= cfg_data;
        end
    end

    // Sequencer: divide until the quotient is zero or the store is full, then read digits back
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        div_start    = 1'b0;
        div_dividend = s_tdata;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    div_start  = 1'b1;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    if (div_quotient != '0 && count_reg < COUNT_W'(MAX_DIGITS - 1)) begin
                        div_start    = 1'b1;
                        div_dividend = div_quotient;
                    end else begin
                        idx_next   = count_reg[DIGIT_IDX_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                mem_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - DIGIT_IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Digit store: write remainders, registered read for emission
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[count_reg[DIGIT_IDX_W-1:0]] <= div_remainder;
        end
        if (mem_re) begin
            rd_data_reg <= digit_mem[idx_reg];
        end
    end

    // Handshake and result
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {1'b0, glyph(rd_data_reg)};
    assign m_tlast  = (idx_reg == '0);

endmodule

@@ test/integer_to_radix_digits_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit_tb
// Self-checking bench for the radix digit converter. Values go in on the
// s_ stream and digits come back on the m_ stream. A local model predicts
// every digit and its tlast flag, and each result is checked against the
// oldest expected digit. Covered: radix clamping at both ends, the zero
// value, full-width values in base 2, back-pressure that fills the block,
// and random values over many bases with random idle bursts.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit_tb;
    import itr_pkg::*;

    // One expected result: ASCII glyph and end-of-number flag
    typedef struct packed {
        logic [CHAR_W-1:0] glyph_code;
        logic              last;
    } digit_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [RADIX_W-1:0]     cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VALUE_WIDTH-1:0] s_tdata;     // value
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;     // digit_char [6:0], zero pad [7]
    logic                   m_tlast;     // last_digit

    digit_t             pending_digits[$];
    logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
    int                 mismatch_count = 0;
    bit                 idle_on = 1'b1;
    int                 hold_left = 0;

    integer_to_radix_digits_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Base actually used for a register value
    function automatic logic [RADIX_W-1:0] effective_base(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    // Divide down, then queue the digits most significant first
    function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value);
        logic [RADIX_W-1:0]     base;
        logic [VALUE_WIDTH-1:0] quot;
        logic [3:0]             rem [0:MAX_DIGITS-1];
        int                     n;
        digit_t                 d;
        base = effective_base(radix_setting);
        quot = value;
        n    = 0;
        if (quot == '0) begin
            rem[0] = 4'd0;
            n      = 1;
        end else begin
            while (quot != '0 && n < MAX_DIGITS) begin
                rem[n] = 4'(quot % VALUE_WIDTH'(base));
                quot   = quot / VALUE_WIDTH'(base);
                n++;
            end
        end
        for (int k = n - 1; k >= 0; k--) begin
            if (rem[k] < 4'd10) begin
                d.glyph_code = 7'h30 + 7'(rem[k]);
            end else begin
                d.glyph_code = 7'h41 + 7'(rem[k] - 4'd10);
            end
            d.last = (k == 0);
            pending_digits.push_back(d);
        end
    endfunction

    // Random value shaped to hit digit-count boundaries of the current base
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [63:0]            p;
        logic [VALUE_WIDTH-1:0] v;
        int                     k;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 255);
            2: v = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            3: v = 32'h1 << $urandom_range(0, 31);
            4: begin
                p = 64'd1;
                k = int'($urandom_range(1, 32));
                repeat (k) begin
                    if (p * 64'(effective_base(radix_setting)) <= 64'hFFFF_FFFF) begin
                        p = p * 64'(effective_base(radix_setting));
                    end
                end
                v = p[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default: v = $urandom() & $urandom();
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 30) begin
            $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
        end
    endtask

    // Check each accepted digit against the oldest expectation
    always @(posedge aclk) begin
        digit_t d;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_digits.size() == 0) begin
                report_mismatch("unexpected digit", {23'd0, m_tlast, m_tdata}, 32'd0);
            end else begin
                d = pending_digits.pop_front();
                if (m_tdata !== {1'b0, d.glyph_code}) begin
                    report_mismatch("digit_char", {24'd0, m_tdata}, {25'd0, d.glyph_code});
                end
                if (m_tlast !== d.last) begin
                    report_mismatch("last_digit", {31'd0, m_tlast}, {31'd0, d.last});
                end
            end
        end
    end

    // Result side ready: long hold-offs first, then random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one value, with an optional idle burst before it
    task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        predict_digits(value);
    endtask

    // Drop the request and wait until every expected digit has come
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(negedge aclk);
    endtask

    // Write the radix register; only called with the block idle
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge aclk); while (!cfg_ready);
        radix_setting = r;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reset base of 16: zero, extremes and all letter digits
    task automatic test_reset_base();
        send_value(32'h0000_0000);
        send_value(32'h0000_0001);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h0123_ABCD);
        send_value(32'hFEDC_BA98);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd16);
    endtask

    // Clamping below two and above sixteen, plus the widest conversions
    task automatic test_radix_clamp();
        write_radix(5'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_0000);
        write_radix(5'd1);
        send_value(32'h8000_0000);
        send_value(32'h0000_0001);
        write_radix(RADIX_MIN);
        send_value(32'd5);
        write_radix(5'd31);
        send_value(32'hFEDC_BA98);
        write_radix(5'd17);
        send_value(32'd255);
        write_radix(5'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1_000_000_000);
        send_value(32'd999_999_999);
        send_value(32'd9);
        write_radix(5'd3);
        send_value(32'hFFFF_FFFF);
        write_radix(5'd15);
        send_value(32'hFFFF_FFFF);
    endtask

    // Random values over a series of random register settings
    task automatic test_random_bases();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                write_radix(RADIX_MAX);
            end else if (phase == 1) begin
                write_radix(RADIX_MIN);
            end else begin
                write_radix(RADIX_W'($urandom_range(0, 31)));
            end
            repeat (50) send_value(pick_value());
        end
    endtask

    // Hold the result side off so the block stalls its input, then pause
    task automatic test_backpressure();
        write_radix(5'd7);
        @(negedge aclk);
        hold_left = 400;
        repeat (6) send_value(pick_value());
        drain();
        repeat (4) send_value(pick_value());
    endtask

    // Steady stream with no idling on either side
    task automatic test_steady_stream();
        write_radix(RADIX_W'($urandom_range(2, 16)));
        idle_on = 1'b0;
        repeat (30) send_value(pick_value());
        write_radix(RADIX_W'($urandom_range(2, 16)));
        repeat (30) send_value(pick_value());
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_base();
        test_radix_clamp();
        test_random_bases();
        test_backpressure();
        test_steady_stream();
        drain();
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("integer_to_radix_digits_unit verification clean");
        end else begin
            $display("integer_to_radix_digits_unit verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20_000_000);
        $display("integer_to_radix_digits_unit verification failed");
        $finish;
    end

endmodule
